@@ rtl/core/vector3_arithmetic_unit_assert.svh @@
// assertion macros for the vector arithmetic unit
// expects clk and rst_n in the scope of each use
`ifndef VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define V3AU_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("v3au assertion failed");

// next-cycle implication
`define V3AU_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("v3au assertion failed");

`else

`define V3AU_ASSERT_IMPL(name, pre, post)
`define V3AU_ASSERT_NEXT(name, pre, post)

`endif

`endif

@@ rtl/core/v3au_pkg.sv @@
// shared types, operation codes and saturation helpers for the vector unit
// no dependencies
package v3au_pkg;

    // operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_DOT   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_CROSS = 3'd4;
    localparam logic [2:0] OP_DIST  = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;

    // square root: radicand is a Q16.16 sum of squares, root is Q16.16 length
    localparam int RAD_W   = 34;
    localparam int FRAC_SH = 16;
    localparam int ROOT_W  = 25;
    localparam int REM_W   = 52;

    // normalize divide: quotient magnitude never exceeds 1.0 in Q8.8
    localparam int DIV_W   = 9;
    localparam int DREM_W  = 34;

    // stages from square root entry to divide exit
    localparam int PIPE_W  = ROOT_W + DIV_W;

    typedef struct packed {
        logic signed [15:0] v;
        logic               f;
    } sat16_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic               f;
    } sat32_t;

    // item state carried beside the square root and divide stages
    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [31:0] scalar;
        logic               sat;
        logic               zl;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
    } side_t;

    function automatic sat16_t clamp16(input logic signed [39:0] v);
        sat16_t res;
        if (v > 40'sd32767)
        begin
            res.v = 16'sh7fff;
            res.f = 1'b1;
        end
        else if (v < -40'sd32768)
        begin
            res.v = 16'sh8000;
            res.f = 1'b1;
        end
        else
        begin
            res.v = v[15:0];
            res.f = 1'b0;
        end
        return res;
    endfunction

    function automatic sat32_t clamp32(input logic signed [39:0] v);
        sat32_t res;
        if (v > 40'sd2147483647)
        begin
            res.v = 32'sh7fffffff;
            res.f = 1'b1;
        end
        else if (v < -40'sd2147483648)
        begin
            res.v = 32'sh80000000;
            res.f = 1'b1;
        end
        else
        begin
            res.v = v[31:0];
            res.f = 1'b0;
        end
        return res;
    endfunction

    // q16.16 to q8.8, ties toward plus infinity, then saturate
    function automatic sat16_t round_q88(input logic signed [39:0] p);
        logic signed [39:0] t;
        t = (p + 40'sd128) >>> 8;
        return clamp16(t);
    endfunction

endpackage

@@ rtl/core/v3au_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on v3au_pkg
module v3au_sqrt
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [v3au_pkg::RAD_W-1:0]    rad,
    output logic [v3au_pkg::ROOT_W-1:0]   root
);

    logic [v3au_pkg::REM_W-1:0]  rem_reg  [v3au_pkg::ROOT_W];
    logic [v3au_pkg::ROOT_W-1:0] root_reg [v3au_pkg::ROOT_W];

    genvar i;
    generate
        for (i = 0; i < v3au_pkg::ROOT_W; i++)
        begin : g_stage
            localparam int B = v3au_pkg::ROOT_W - 1 - i;
            logic [v3au_pkg::REM_W-1:0]  rem_in;
            logic [v3au_pkg::REM_W-1:0]  trial;
            logic [v3au_pkg::REM_W-1:0]  rem_next;
            logic [v3au_pkg::ROOT_W-1:0] root_in;
            logic [v3au_pkg::ROOT_W-1:0] root_next;

            // first stage takes the radicand scaled to q32
            if (i == 0)
            begin : g_first
                assign rem_in  = v3au_pkg::REM_W'(rad) << v3au_pkg::FRAC_SH;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
            end

            // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
            assign trial = (v3au_pkg::REM_W'(root_in) << (B + 1))
                         | (v3au_pkg::REM_W'(1) << (2 * B));

            always_comb
            begin
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = root_in | (v3au_pkg::ROOT_W'(1) << B);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[v3au_pkg::ROOT_W-1];

endmodule

@@ rtl/core/v3au_div.sv @@
// pipelined restoring divide for normalize, three lanes, one quotient bit per stage
// depends on v3au_pkg
module v3au_div
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [v3au_pkg::ROOT_W-1:0]   len,
    input  logic signed [15:0]            num [3],
    output logic signed [15:0]            quo [3],
    output logic [v3au_pkg::ROOT_W-1:0]   len_out
);

    logic [v3au_pkg::DREM_W-1:0] rem_reg [v3au_pkg::DIV_W][3];
    logic [v3au_pkg::DIV_W-1:0]  q_reg   [v3au_pkg::DIV_W][3];
    logic                        neg_reg [v3au_pkg::DIV_W][3];
    logic [v3au_pkg::ROOT_W-1:0] len_reg [v3au_pkg::DIV_W];

    genvar j;
    generate
        for (j = 0; j < v3au_pkg::DIV_W; j++)
        begin : g_stage
            localparam int B = v3au_pkg::DIV_W - 1 - j;
            logic [v3au_pkg::DREM_W-1:0] rem_in   [3];
            logic [v3au_pkg::DIV_W-1:0]  q_in     [3];
            logic                        neg_in   [3];
            logic [v3au_pkg::ROOT_W-1:0] len_in;
            logic [v3au_pkg::DREM_W-1:0] dv;
            logic [v3au_pkg::DREM_W-1:0] rem_next [3];
            logic [v3au_pkg::DIV_W-1:0]  q_next   [3];

            // first stage splits sign and magnitude, dividend is |c| * 65536
            if (j == 0)
            begin : g_first
                for (genvar c = 0; c < 3; c++)
                begin : g_lane
                    logic [15:0] mag;
                    assign neg_in[c] = num[c][15];
                    assign mag       = num[c][15] ? 16'(-num[c]) : 16'(num[c]);
                    assign rem_in[c] = v3au_pkg::DREM_W'(mag) << v3au_pkg::FRAC_SH;
                    assign q_in[c]   = '0;
                end
                assign len_in = len;
            end
            else
            begin : g_rest
                for (genvar c = 0; c < 3; c++)
                begin : g_lane
                    assign neg_in[c] = neg_reg[j-1][c];
                    assign rem_in[c] = rem_reg[j-1][c];
                    assign q_in[c]   = q_reg[j-1][c];
                end
                assign len_in = len_reg[j-1];
            end

            assign dv = v3au_pkg::DREM_W'(len_in) << B;

            // trial subtract per lane
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (rem_in[c] >= dv)
                    begin
                        rem_next[c] = rem_in[c] - dv;
                        q_next[c]   = q_in[c] | (v3au_pkg::DIV_W'(1) << B);
                    end
                    else
                    begin
                        rem_next[c] = rem_in[c];
                        q_next[c]   = q_in[c];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_reg[j][c] <= rem_next[c];
                        q_reg[j][c]   <= q_next[c];
                        neg_reg[j][c] <= neg_in[c];
                    end
                    len_reg[j] <= len_in;
                end
            end
        end
    endgenerate

    // reapply sign, truncation toward zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (neg_reg[v3au_pkg::DIV_W-1][c])
                quo[c] = -$signed(16'(q_reg[v3au_pkg::DIV_W-1][c]));
            else
                quo[c] = $signed(16'(q_reg[v3au_pkg::DIV_W-1][c]));
        end
    end

    assign len_out = len_reg[v3au_pkg::DIV_W-1];

endmodule

@@ rtl/core/vector3_arithmetic_unit.sv @@
// Three-component Q8.8 vector unit: add, sub, dot, scale, cross, distance, normalize.
// Fully pipelined, takes one transfer per cycle. There are 38 register stages: input
// stage, multiply stage, combine stage, 25 square root stages (one root bit each),
// 9 normalize divide stages (one quotient bit each) and the output register.
// Every operation walks the same path so results leave in order. The whole pipeline
// holds while a result sits on the output with out_stall high.
// depends on v3au_pkg, v3au_sqrt, v3au_div and vector3_arithmetic_unit_assert.svh
module vector3_arithmetic_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] scale_factor,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] r_x,
    output logic signed [15:0] r_y,
    output logic signed [15:0] r_z,
    output logic signed [31:0] scalar_out,
    output logic               zero_length,
    output logic               saturated
);

    logic en;

    logic signed [15:0] ain [3];
    logic signed [15:0] bin [3];
    logic signed [16:0] d_next  [3];
    v3au_pkg::sat16_t   as_next [3];

    // stage 1: operands, differences, add/sub results
    logic               vld1_reg;
    logic [2:0]         op1_reg;
    logic signed [15:0] a1_reg [3];
    logic signed [15:0] b1_reg [3];
    logic signed [15:0] k1_reg;
    logic signed [16:0] d1_reg [3];
    logic signed [15:0] as1_reg [3];
    logic               as_sat1_reg;

    // stage 2: products
    logic signed [16:0] ma [6];
    logic signed [16:0] mb [6];
    logic               vld2_reg;
    logic [2:0]         op2_reg;
    logic signed [15:0] a2_reg [3];
    logic signed [33:0] p2_reg [6];
    logic signed [15:0] as2_reg [3];
    logic               as_sat2_reg;

    // stage 3: combine
    logic signed [35:0] sum3;
    logic signed [35:0] e3 [3];
    v3au_pkg::side_t    side3_next;
    v3au_pkg::sat16_t   rq [3];
    v3au_pkg::sat32_t   dq;
    logic               vld3_reg;
    v3au_pkg::side_t    side3_reg;
    logic [v3au_pkg::RAD_W-1:0] rad3_reg;

    // side line beside square root and divide
    logic [v3au_pkg::PIPE_W-1:0] vld_reg;
    v3au_pkg::side_t             side_reg [v3au_pkg::PIPE_W];
    v3au_pkg::side_t             side_mid;
    v3au_pkg::side_t             side_end;
    logic [v3au_pkg::ROOT_W-1:0] root;
    logic [v3au_pkg::ROOT_W-1:0] len_out;
    logic signed [15:0]          num [3];
    logic signed [15:0]          q [3];

    // output register
    logic               out_valid_reg;
    logic signed [15:0] r_x_reg;
    logic signed [15:0] r_y_reg;
    logic signed [15:0] r_z_reg;
    logic signed [31:0] scalar_reg;
    logic               zl_reg;
    logic               sat_reg;
    logic signed [15:0] r_x_next;
    logic signed [15:0] r_y_next;
    logic signed [15:0] r_z_next;
    logic signed [31:0] scalar_next;
    logic               zl_next;
    logic               sat_next;

    // pipeline advances unless a held result blocks the output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign ain[0] = a_x;
    assign ain[1] = a_y;
    assign ain[2] = a_z;
    assign bin[0] = b_x;
    assign bin[1] = b_y;
    assign bin[2] = b_z;

    // add/sub and differences
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d_next[c] = {ain[c][15], ain[c]} - {bin[c][15], bin[c]};
            if (func == v3au_pkg::OP_SUB)
                as_next[c] = v3au_pkg::clamp16(40'(d_next[c]));
            else
                as_next[c] = v3au_pkg::clamp16(40'($signed({ain[c][15], ain[c]}
                                                           + {bin[c][15], bin[c]})));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg     <= func;
            k1_reg      <= scale_factor;
            as_sat1_reg <= as_next[0].f | as_next[1].f | as_next[2].f;
            for (int c = 0; c < 3; c++)
            begin
                a1_reg[c]  <= ain[c];
                b1_reg[c]  <= bin[c];
                d1_reg[c]  <= d_next[c];
                as1_reg[c] <= as_next[c].v;
            end
        end
    end

    // multiplier operand select
    always_comb
    begin
        for (int c = 0; c < 6; c++)
        begin
            ma[c] = '0;
            mb[c] = '0;
        end
        unique case (op1_reg)
            v3au_pkg::OP_DOT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ma[c] = {a1_reg[c][15], a1_reg[c]};
                    mb[c] = {b1_reg[c][15], b1_reg[c]};
                end
            end
            v3au_pkg::OP_SCALE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ma[c] = {a1_reg[c][15], a1_reg[c]};
                    mb[c] = {k1_reg[15], k1_reg};
                end
            end
            v3au_pkg::OP_CROSS:
            begin
                ma[0] = {a1_reg[1][15], a1_reg[1]};
                mb[0] = {b1_reg[2][15], b1_reg[2]};
                ma[1] = {a1_reg[2][15], a1_reg[2]};
                mb[1] = {b1_reg[1][15], b1_reg[1]};
                ma[2] = {a1_reg[2][15], a1_reg[2]};
                mb[2] = {b1_reg[0][15], b1_reg[0]};
                ma[3] = {a1_reg[0][15], a1_reg[0]};
                mb[3] = {b1_reg[2][15], b1_reg[2]};
                ma[4] = {a1_reg[0][15], a1_reg[0]};
                mb[4] = {b1_reg[1][15], b1_reg[1]};
                ma[5] = {a1_reg[1][15], a1_reg[1]};
                mb[5] = {b1_reg[0][15], b1_reg[0]};
            end
            v3au_pkg::OP_DIST:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ma[c] = d1_reg[c];
                    mb[c] = d1_reg[c];
                end
            end
            v3au_pkg::OP_NORM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ma[c] = {a1_reg[c][15], a1_reg[c]};
                    mb[c] = {a1_reg[c][15], a1_reg[c]};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg     <= op1_reg;
            as_sat2_reg <= as_sat1_reg;
            for (int c = 0; c < 3; c++)
            begin
                a2_reg[c]  <= a1_reg[c];
                as2_reg[c] <= as1_reg[c];
            end
            for (int c = 0; c < 6; c++)
                p2_reg[c] <= ma[c] * mb[c];
        end
    end

    // combine products into results
    assign sum3 = 36'(p2_reg[0]) + 36'(p2_reg[1]) + 36'(p2_reg[2]);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            e3[c] = 36'(p2_reg[2*c]) - 36'(p2_reg[2*c+1]);
            if (op2_reg == v3au_pkg::OP_CROSS)
                rq[c] = v3au_pkg::round_q88(40'(e3[c]));
            else
                rq[c] = v3au_pkg::round_q88(40'(p2_reg[c]));
        end
        dq = v3au_pkg::clamp32(40'(sum3));

        side3_next.op     = op2_reg;
        side3_next.r_x    = '0;
        side3_next.r_y    = '0;
        side3_next.r_z    = '0;
        side3_next.scalar = '0;
        side3_next.sat    = 1'b0;
        side3_next.zl     = (sum3 == '0);
        side3_next.a_x    = a2_reg[0];
        side3_next.a_y    = a2_reg[1];
        side3_next.a_z    = a2_reg[2];

        unique case (op2_reg)
            v3au_pkg::OP_ADD, v3au_pkg::OP_SUB:
            begin
                side3_next.r_x = as2_reg[0];
                side3_next.r_y = as2_reg[1];
                side3_next.r_z = as2_reg[2];
                side3_next.sat = as_sat2_reg;
            end
            v3au_pkg::OP_DOT:
            begin
                side3_next.scalar = dq.v;
                side3_next.sat    = dq.f;
            end
            v3au_pkg::OP_SCALE, v3au_pkg::OP_CROSS:
            begin
                side3_next.r_x = rq[0].v;
                side3_next.r_y = rq[1].v;
                side3_next.r_z = rq[2].v;
                side3_next.sat = rq[0].f | rq[1].f | rq[2].f;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side3_next;
            rad3_reg  <= sum3[v3au_pkg::RAD_W-1:0];
        end
    end

    // side line shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side3_reg;
            for (int i = 1; i < v3au_pkg::PIPE_W; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg      <= in_valid;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            vld_reg       <= {vld_reg[v3au_pkg::PIPE_W-2:0], vld3_reg};
            out_valid_reg <= vld_reg[v3au_pkg::PIPE_W-1];
        end
    end

    v3au_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (rad3_reg),
        .root (root)
    );

    assign side_mid = side_reg[v3au_pkg::ROOT_W-1];
    assign num[0]   = side_mid.a_x;
    assign num[1]   = side_mid.a_y;
    assign num[2]   = side_mid.a_z;

    v3au_div u_div
    (
        .clk     (clk),
        .en      (en),
        .len     (root),
        .num     (num),
        .quo     (q),
        .len_out (len_out)
    );

    assign side_end = side_reg[v3au_pkg::PIPE_W-1];

    // final select for distance and normalize
    always_comb
    begin
        r_x_next    = side_end.r_x;
        r_y_next    = side_end.r_y;
        r_z_next    = side_end.r_z;
        scalar_next = side_end.scalar;
        zl_next     = 1'b0;
        sat_next    = side_end.sat;
        if (side_end.op == v3au_pkg::OP_DIST)
            scalar_next = 32'(len_out);
        if (side_end.op == v3au_pkg::OP_NORM)
        begin
            zl_next = side_end.zl;
            if (!side_end.zl)
            begin
                r_x_next = q[0];
                r_y_next = q[1];
                r_z_next = q[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_x_reg    <= r_x_next;
            r_y_reg    <= r_y_next;
            r_z_reg    <= r_z_next;
            scalar_reg <= scalar_next;
            zl_reg     <= zl_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign r_x         = r_x_reg;
    assign r_y         = r_y_reg;
    assign r_z         = r_z_reg;
    assign scalar_out  = scalar_reg;
    assign zero_length = zl_reg;
    assign saturated   = sat_reg;

    // checks
`include "vector3_arithmetic_unit_assert.svh"

    `V3AU_ASSERT_IMPL(a_held_result_stalls_input, out_valid_reg && out_stall, in_stall)
    `V3AU_ASSERT_IMPL(a_zero_length_clean, out_valid_reg && zero_length, r_x == 16'sd0 && r_y == 16'sd0 && r_z == 16'sd0 && scalar_out == 32'sd0 && !saturated)
    `V3AU_ASSERT_NEXT(a_tail_reaches_output, en && vld_reg[v3au_pkg::PIPE_W-1], out_valid_reg)
    `V3AU_ASSERT_IMPL(a_norm_within_unit, vld_reg[v3au_pkg::PIPE_W-1] && side_end.op == v3au_pkg::OP_NORM && !side_end.zl, q[0] <= 16'sd256 && q[0] >= -16'sd256 && q[1] <= 16'sd256 && q[1] >= -16'sd256)

endmodule
